// File: hw/rtl/hkvt_pkg.sv
`default_nettype none

package hkvt_pkg;

    localparam int HASH_W      = 32;
    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int POS_W       = 4;
    localparam int COUNT_OUT_W = 5;

    typedef logic [HASH_W-1:0]  hash_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [1:0]         mode_t;
    typedef logic [1:0]         status_t;

    localparam mode_t MODE_INSERT = 2'd0;
    localparam mode_t MODE_REMOVE = 2'd1;
    localparam mode_t MODE_LOOKUP = 2'd2;

    localparam status_t STATUS_DONE      = 2'd0;
    localparam status_t STATUS_NOT_FOUND = 2'd1;
    localparam status_t STATUS_FULL      = 2'd2;

    localparam logic [POS_W-1:0] POS_LAST = 4'd9;

    localparam value_t NOT_FOUND_VALUE = 32'h7FFF_FFFF;

    // table operation broadcast to every cell
    typedef struct packed {
        logic   fire;
        mode_t  mode;
        hash_t  hash;
        value_t value;
    } cmd_t;

    // one stored pair, handed to the left neighbor for a remove shift
    typedef struct packed {
        hash_t  hash;
        value_t value;
    } cell_data_t;

    // first-match chain running from cell 0 toward the tail
    typedef struct packed {
        logic   found;
        value_t value;
    } link_t;

endpackage

`default_nettype wire

// File: hw/rtl/hkvt_hash.sv
`default_nettype none

module hkvt_hash
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire logic [7:0]              key_char,
    input  wire logic                    key_last,
    output      hkvt_pkg::hash_t         hash
);
    import hkvt_pkg::*;

    hash_t             acc_reg;
    hash_t             acc_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [POS_W+CHAR_W-1:0] product;

    always_comb
    begin
        product = {{CHAR_W{1'b0}}, pos_reg} * {{POS_W{1'b0}}, key_char};
        hash    = acc_reg + {{(HASH_W-POS_W-CHAR_W){1'b0}}, product};
        if (key_last)
        begin
            acc_next = '0;
            pos_next = '0;
        end
        else
        begin
            acc_next = hash;
            pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            pos_reg <= '0;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/hkvt_cell.sv
`default_nettype none

module hkvt_cell
(
    input  wire logic                    clk,
    input  wire hkvt_pkg::cmd_t          cmd,
    input  wire logic                    occ,
    input  wire logic                    occ_prev,
    input  wire hkvt_pkg::cell_data_t    right_data,
    input  wire hkvt_pkg::link_t         link_in,
    output      hkvt_pkg::link_t         link_out,
    output      hkvt_pkg::cell_data_t    data
);
    import hkvt_pkg::*;

    cell_data_t data_reg;
    logic       match;
    logic       is_tail;

    assign data    = data_reg;
    assign match   = occ && (data_reg.hash == cmd.hash);
    assign is_tail = !occ && occ_prev;

    always_comb
    begin
        link_out.found = link_in.found || match;
        link_out.value = (match && !link_in.found) ? data_reg.value : link_in.value;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fire)
        begin
            case (cmd.mode)
                MODE_INSERT:
                begin
                    if (is_tail)
                    begin
                        data_reg.hash  <= cmd.hash;
                        data_reg.value <= cmd.value;
                    end
                end
                MODE_REMOVE:
                begin
                    if (occ && link_out.found)
                        data_reg <= right_data;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/hashed_key_value_table.sv
// After the last key character is accepted, the operation waits in the command register until the output
// can take it; out_valid is registered when it fires. One key character per cycle while in_stall is low.
// The table operation runs in the cell chain when the command fires, overlapped with the next key.
// Reset clears the hash, character position, entry count and both handshakes;
// table contents are undefined until written and never read before that.
`default_nettype none

module hashed_key_value_table
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output      logic                    in_stall,
    input  wire logic [1:0]              mode,
    input  wire logic [7:0]              key_char,
    input  wire logic                    key_last,
    input  wire logic signed [31:0]      entry_value,
    output      logic                    out_valid,
    input  wire logic                    out_stall,
    output      logic [1:0]              status,
    output      logic signed [31:0]      found_value,
    output      logic signed [31:0]      key_hash,
    output      logic [4:0]              entry_count
);
    import hkvt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic        in_fire;
    logic        op_fire;
    hash_t       hash;

    logic        cmd_valid_reg;
    mode_t       cmd_mode_reg;
    hash_t       cmd_hash_reg;
    value_t      cmd_value_reg;
    cmd_t        cmd;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             full;
    logic             hit;

    logic        out_valid_reg;
    status_t     status_reg;
    status_t     status_next;
    value_t      found_reg;
    value_t      found_next;
    hash_t       hash_out_reg;
    logic [COUNT_OUT_W-1:0] count_out_reg;
    logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

    logic [TABLE_DEPTH-1:0] occ;
    cell_data_t             cell_data [TABLE_DEPTH+1];
    link_t                  link      [TABLE_DEPTH+1];

    assign op_fire  = cmd_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = cmd_valid_reg && !op_fire;
    assign in_fire  = in_valid && !in_stall;

    hkvt_hash u_hash
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (in_fire),
        .key_char (key_char),
        .key_last (key_last),
        .hash     (hash)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else if (in_fire && key_last)
            cmd_valid_reg <= 1'b1;
        else if (op_fire)
            cmd_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && key_last)
        begin
            cmd_mode_reg  <= mode;
            cmd_hash_reg  <= hash;
            cmd_value_reg <= entry_value;
        end
    end

    always_comb
    begin
        cmd.fire  = op_fire;
        cmd.mode  = cmd_mode_reg;
        cmd.hash  = cmd_hash_reg;
        cmd.value = cmd_value_reg;
    end

    assign link[0].found        = 1'b0;
    assign link[0].value        = NOT_FOUND_VALUE;
    assign cell_data[TABLE_DEPTH] = cell_data[TABLE_DEPTH-1];

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic occ_prev;

        assign occ[i] = count_reg > CNT_W'(i);

        if (i == 0)
        begin : g_head
            assign occ_prev = 1'b1;
        end
        else
        begin : g_body
            assign occ_prev = occ[i-1];
        end

        hkvt_cell u_cell
        (
            .clk        (clk),
            .cmd        (cmd),
            .occ        (occ[i]),
            .occ_prev   (occ_prev),
            .right_data (cell_data[i+1]),
            .link_in    (link[i]),
            .link_out   (link[i+1]),
            .data       (cell_data[i])
        );
    end

    assign full = count_reg == CNT_W'(TABLE_DEPTH);
    assign hit  = link[TABLE_DEPTH].found;

    always_comb
    begin
        count_next  = count_reg;
        status_next = STATUS_DONE;
        found_next  = NOT_FOUND_VALUE;
        case (cmd_mode_reg)
            MODE_INSERT:
            begin
                if (full)
                    status_next = STATUS_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            MODE_REMOVE:
            begin
                if (hit)
                    count_next = count_reg - 1'b1;
                else
                    status_next = STATUS_NOT_FOUND;
            end
            MODE_LOOKUP:
            begin
                if (hit)
                    found_next = link[TABLE_DEPTH].value;
                else
                    status_next = STATUS_NOT_FOUND;
            end
            default:
            begin
            end
        endcase
        count_wide = {{COUNT_OUT_W{1'b0}}, count_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op_fire)
                count_reg <= count_next;
            if (op_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_fire)
        begin
            status_reg    <= status_next;
            found_reg     <= found_next;
            hash_out_reg  <= cmd_hash_reg;
            count_out_reg <= count_wide[COUNT_OUT_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_value = found_reg;
    assign key_hash    = hash_out_reg;
    assign entry_count = count_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (op_fire && cmd_mode_reg == MODE_REMOVE && hit)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("remove hit did not shrink the table");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STATUS_FULL) |-> full)
        else $error("full status reported on a table with room");

endmodule

`default_nettype wire

// File: tb/hashed_key_value_table_tb.sv
`default_nettype none

module hashed_key_value_table_tb;
    import hkvt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BANK_N  = 12;
    localparam int MAX_KEY_LEN = 24;
    localparam int ITEM_TARGET = 500;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;

    localparam mode_t MODE_UNUSED = 2'd3;

    typedef struct packed {
        status_t            st;
        logic [VALUE_W-1:0] value;
        logic [HASH_W-1:0]  hash;
        logic [4:0]         count;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    mode_t mode;
    logic [7:0] key_char;
    logic key_last;
    logic signed [31:0] entry_value;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic signed [31:0] found_value;
    logic signed [31:0] key_hash;
    logic [4:0] entry_count;

    // shadow of the table
    logic [HASH_W-1:0]  hash_acc;
    logic [POS_W-1:0]   char_pos;
    logic [HASH_W-1:0]  shadow_hash [TABLE_DEPTH];
    logic [VALUE_W-1:0] shadow_value [TABLE_DEPTH];
    int                 shadow_count;
    table_result_t      pending_results [$];

    logic [7:0] key_bank [KEY_BANK_N][MAX_KEY_LEN];
    int         key_len [KEY_BANK_N];

    int fail_count = 0;
    int chars_sent = 0;
    int cycle_count = 0;
    bit tx_gaps_on = 1'b1;
    bit rx_stalls_on = 1'b1;
    int rx_hold_left = 0;
    int rx_run_left = 0;
    int rx_roll;

    hashed_key_value_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .key_char(key_char),
        .key_last(key_last),
        .entry_value(entry_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .found_value(found_value),
        .key_hash(key_hash),
        .entry_count(entry_count)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic apply_char(input mode_t m, input logic [7:0] c, input logic l,
                              input logic [VALUE_W-1:0] v);
        table_result_t r;
        int idx;
        int i;
        hash_acc = hash_acc + 32'(char_pos) * 32'(c);
        char_pos = (char_pos == POS_LAST) ? '0 : char_pos + 1'b1;
        if (!l)
            return;
        r.hash = hash_acc;
        r.st = STATUS_DONE;
        r.value = NOT_FOUND_VALUE;
        hash_acc = '0;
        char_pos = '0;
        idx = -1;
        for (i = 0; i < shadow_count; i++)
            if (idx < 0 && shadow_hash[i] == r.hash)
                idx = i;
        case (m)
            MODE_INSERT:
                if (shadow_count >= TABLE_DEPTH)
                    r.st = STATUS_FULL;
                else
                begin
                    shadow_hash[shadow_count] = r.hash;
                    shadow_value[shadow_count] = v;
                    shadow_count++;
                end
            MODE_REMOVE:
                if (idx < 0)
                    r.st = STATUS_NOT_FOUND;
                else
                begin
                    for (i = idx; i + 1 < shadow_count; i++)
                    begin
                        shadow_hash[i] = shadow_hash[i + 1];
                        shadow_value[i] = shadow_value[i + 1];
                    end
                    shadow_count--;
                end
            MODE_LOOKUP:
                if (idx < 0)
                    r.st = STATUS_NOT_FOUND;
                else
                    r.value = shadow_value[idx];
            default: ;
        endcase
        r.count = 5'(shadow_count);
        pending_results.push_back(r);
    endtask

    always @(posedge clk)
        if (rst_n && in_valid && !in_stall)
            apply_char(mode, key_char, key_last, entry_value);

    always @(posedge clk)
    begin
        table_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected transaction: status=%0d hash=%0d count=%0d",
                       status, key_hash, entry_count);
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.st)
                begin
                    $error("status: expected %0d, got %0d", e.st, status);
                    fail_count++;
                end
                if (found_value !== e.value)
                begin
                    $error("found_value: expected %0d, got %0d", $signed(e.value), found_value);
                    fail_count++;
                end
                if (key_hash !== e.hash)
                begin
                    $error("key_hash: expected %0d, got %0d", $signed(e.hash), key_hash);
                    fail_count++;
                end
                if (entry_count !== e.count)
                begin
                    $error("entry_count: expected %0d, got %0d", e.count, entry_count);
                    fail_count++;
                end
            end
        end
    end

    // receiver: long hold-off on request, otherwise random stall runs while stalls are enabled
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_stall <= 1'b1;
        end
        else if (!rx_stalls_on)
            out_stall <= 1'b0;
        else if (rx_run_left > 0)
        begin
            rx_run_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 70)
                out_stall <= 1'b0;
            else
            begin
                rx_run_left = (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                out_stall <= 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!tx_gaps_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_char(input mode_t m, input logic [7:0] c, input logic l,
                             input logic [VALUE_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        mode <= m;
        key_char <= c;
        key_last <= l;
        entry_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        chars_sent++;
    endtask

    // mode and value only matter on the last character; earlier ones carry noise
    task automatic send_key(input int k, input mode_t m, input logic [VALUE_W-1:0] v);
        int i;
        logic l;
        for (i = 0; i < key_len[k]; i++)
        begin
            l = (i == key_len[k] - 1);
            send_char(l ? m : mode_t'($urandom_range(0, 3)), key_bank[k][i], l,
                      l ? v : $urandom());
        end
    endtask

    task automatic make_key(input int k);
        int r;
        int i;
        r = $urandom_range(0, 99);
        key_len[k] = (r < 50) ? $urandom_range(1, 3) :
                     (r < 85) ? $urandom_range(4, 10) : $urandom_range(11, MAX_KEY_LEN);
        for (i = 0; i < MAX_KEY_LEN; i++)
        begin
            r = $urandom_range(0, 9);
            key_bank[k][i] = (r == 0) ? 8'hFF : (r == 1) ? 8'h00 : 8'($urandom());
        end
    endtask

    function automatic mode_t pick_mode(input int insert_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
            return MODE_INSERT;
        if (r >= 97)
            return MODE_UNUSED;
        return r[0] ? MODE_REMOVE : MODE_LOOKUP;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 99) >= 25)
            return $urandom();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_ops();
        // empty table
        send_char(MODE_LOOKUP, 8'h00, 1'b1, 32'h1234_5678);
        send_char(MODE_REMOVE, 8'hFF, 1'b1, 32'h0);
        // single character keys always hash to zero
        send_char(MODE_INSERT, 8'h5A, 1'b1, 32'h0000_0000);
        send_char(MODE_LOOKUP, 8'hA5, 1'b1, 32'hFFFF_FFFF);
        // two keys with the same hash of 255
        send_char(MODE_LOOKUP, 8'h00, 1'b0, 32'hFFFF_FFFF);
        send_char(MODE_INSERT, 8'hFF, 1'b1, 32'h8000_0000);
        send_char(MODE_REMOVE, 8'h01, 1'b0, 32'h0);
        send_char(MODE_INSERT, 8'hFF, 1'b1, 32'h7FFF_FFFF);
        send_char(MODE_UNUSED, 8'h77, 1'b0, 32'hAAAA_5555);
        send_char(MODE_LOOKUP, 8'hFF, 1'b1, 32'h5555_AAAA);
        send_char(MODE_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        send_char(MODE_REMOVE, 8'h00, 1'b0, 32'h0);
        send_char(MODE_REMOVE, 8'hFF, 1'b1, 32'h0);
        send_char(MODE_LOOKUP, 8'h10, 1'b0, 32'h0);
        send_char(MODE_LOOKUP, 8'hFF, 1'b1, 32'h0);
        // zero-valued entry removed, then gone
        send_char(MODE_REMOVE, 8'h00, 1'b1, 32'h0);
        send_char(MODE_LOOKUP, 8'h00, 1'b1, 32'h0);
        send_char(MODE_INSERT, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    endtask

    task automatic test_backpressure();
        int k;
        tx_gaps_on = 1'b0;
        rx_hold_left = 150;
        for (k = 0; k < 10; k++)
            send_key($urandom_range(0, KEY_BANK_N - 1), pick_mode(40), pick_value());
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        int k;
        for (k = 0; k < 4; k++)
            send_key($urandom_range(0, KEY_BANK_N - 1), pick_mode(50), pick_value());
        wait_drained();
        for (k = 0; k < 4; k++)
            send_key($urandom_range(0, KEY_BANK_N - 1), pick_mode(50), pick_value());
    endtask

    task automatic test_random_traffic();
        int phase;
        int insert_pct;
        int n_keys;
        int k;
        int j;
        phase = 0;
        while (chars_sent < ITEM_TARGET)
        begin
            case (phase % 3)
                0: begin insert_pct = 85; n_keys = 24; end
                1: begin insert_pct = 40; n_keys = 12; end
                default: begin insert_pct = 10; n_keys = 24; end
            endcase
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            for (j = 0; j < n_keys && chars_sent < ITEM_TARGET; j++)
            begin
                k = $urandom_range(0, KEY_BANK_N - 1);
                if ($urandom_range(0, 99) < 20)
                    make_key(k);
                send_key(k, pick_mode(insert_pct), pick_value());
            end
            phase++;
        end
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_INSERT;
        key_char = '0;
        key_last = 1'b0;
        entry_value = '0;
        hash_acc = '0;
        char_pos = '0;
        shadow_count = 0;
        for (k = 0; k < KEY_BANK_N; k++)
            make_key(k);
        key_len[0] = 1;
        key_len[1] = 1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_ops();
        test_backpressure();
        test_drain_pause();
        test_random_traffic();

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/hkvt_pkg.sv
hw/rtl/hkvt_hash.sv
hw/rtl/hkvt_cell.sv
hw/rtl/hashed_key_value_table.sv
tb/hashed_key_value_table_tb.sv
